[sv/serial_command_line_interpreter_defines.svh]
// Assertion macros for the serial command line interpreter.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SERIAL_COMMAND_LINE_INTERPRETER_DEFINES_SVH
`define SERIAL_COMMAND_LINE_INTERPRETER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCLI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCLI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/scli_pkg.sv]
// Shared types, character codes and helper functions for the command interpreter.
// No dependencies; every design module of the block refers to it by scoped names.
`default_nettype none

package scli_pkg;

   localparam int unsigned LINE_DEPTH_DEF = 64;
   localparam int unsigned QUEUE_DEPTH    = 4;

   // Frequency accumulator: values above PERIOD_MS_NUM all give period zero,
   // so the number saturates just above it.
   localparam int unsigned        NUM_W         = 10;
   localparam logic [NUM_W-1:0]   PERIOD_MS_NUM = 10'd1000;
   localparam logic [NUM_W-1:0]   NUM_CAP       = 10'd1001;
   localparam int unsigned        HDR_LEN       = 5;
   localparam int unsigned        NUM_START     = 3;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_FOUR   = 8'h34;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_A      = 8'h61;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_O      = 8'h6F;
   localparam logic [7:0] CH_U      = 8'h75;

   typedef enum logic [1:0] {
      ITEM_CHAR = 2'd0,
      ITEM_DEL  = 2'd1,
      ITEM_EOL  = 2'd2
   } item_kind_type;

   typedef enum logic [2:0] {
      CMD_INVALID = 3'd0,
      CMD_PERIOD  = 3'd1,
      CMD_BUTTON  = 3'd2,
      CMD_LED     = 3'd3,
      CMD_ADC     = 3'd4
   } cmd_kind_type;

   typedef enum logic [1:0] {
      TGT_UART    = 2'd0,
      TGT_BUTTONS = 2'd1,
      TGT_ADC     = 2'd2,
      TGT_OUTPUTS = 2'd3
   } rate_target_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    rx_byte;
      logic [3:0]    button_levels;
      logic [15:0]   adc_level;
   } q_item_type;

   typedef struct packed {
      cmd_kind_type cmd_kind;
      logic [1:0]   target;
      logic [15:0]  value;
      logic         rate_error;
   } result_type;

   typedef struct packed {
      logic idle;
      logic in_result;
      logic dividing;
   } back_status_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

`default_nettype wire

[sv/serial_command_line_interpreter.sv]
// Top level of the serial command line interpreter: input stage, item queue,
// line engine and divider. Depends on scli_pkg and serial_command_line_interpreter_defines.svh.
//
//   channel | dir | tdata fields (low bit up)                      | item
//   --------+-----+-------------------------------------------------+------------------
//   req_    | in  | rx_byte[7:0] button_levels[11:8] adc_level[27:12]| one received byte
//   rsp_    | out | cmd_kind[2:0] target[4:3] value[20:5] rate_error[21] | decoded line
//
// Flow: an ordinary byte or a delete passes the input stage, then the line engine;
//   a carriage return takes the engine through header decode and result, and for a rate
//   command via a read and an evaluate per character from column three, then the divider.
// The queue holds up to four tagged bytes, so input keeps flowing while a line decodes.
// Reset (synchronous, active high) empties the queue and the line; the store needs no sweep.
// A stalled result holds in the output register; the engine waits to load the next one.
`default_nettype none
`include "serial_command_line_interpreter_defines.svh"

module serial_command_line_interpreter #(
   parameter int unsigned LINE_DEPTH = scli_pkg::LINE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // rx_byte[7:0], button_levels[11:8], adc_level[27:12]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // cmd_kind[2:0], target[4:3], value[20:5], rate_error[21]
);

   logic                            fr_valid;
   logic                            q_in_ready;
   scli_pkg::q_item_type            fr_item;
   logic                            q_valid;
   logic                            q_ready;
   scli_pkg::q_item_type            q_item;
   logic                            div_start;
   logic [scli_pkg::NUM_W-1:0]      div_divisor;
   logic                            div_busy;
   logic                            div_done;
   logic [scli_pkg::NUM_W-1:0]      div_quotient;
   scli_pkg::result_type            result;
   scli_pkg::back_status_type       bk_status;
   logic                            q_pop;

   // Tag each received byte as character, delete or line end.
   scli_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .rx_byte       (req_tdata[7:0]),
      .button_levels (req_tdata[11:8]),
      .adc_level     (req_tdata[27:12]),
      .push_valid    (fr_valid),
      .push_ready    (q_in_ready),
      .push_item     (fr_item)
   );

   // Decouple the input stage from the line engine.
   scli_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (q_in_ready),
      .push_item  (fr_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   // Store the line, decode it on carriage return, hold the result.
   scli_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item),
      .div_start    (div_start),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result),
      .status       (bk_status)
   );

   // Period in ms from the scanned frequency.
   scli_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Pack the result fields, low bit first, padded to whole bytes.
   assign rsp_tdata = {2'b00, result.rate_error, result.value, result.target, result.cmd_kind};
   assign q_pop     = q_valid && q_ready;

   // The engine leaves idle only by taking a line end from the queue.
   `SCLI_ASSERT_IMP(a_leave_idle_on_pop, $fell(bk_status.idle), $past(q_pop), "engine left idle without an item")
   // A new result comes only out of the result state.
   `SCLI_ASSERT_IMP(a_result_source, $rose(rsp_tvalid), $past(bk_status.in_result), "result loaded outside result state")
   // The divider runs only while the engine waits for it.
   `SCLI_ASSERT_IMP(a_div_owned, div_busy, bk_status.dividing, "divider busy while engine not waiting")
   // A finished division moves the engine to its result state.
   `SCLI_ASSERT_NXT(a_div_done_result, div_done, bk_status.in_result, "division done but no result")

endmodule

`default_nettype wire

[sv/scli_front.sv]
// Input stage: accepts received bytes and tags them as character, delete or line end.
// Depends on scli_pkg.
`default_nettype none

module scli_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [3:0]          button_levels,
   input  wire logic [15:0]         adc_level,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output scli_pkg::q_item_type     push_item
);

   logic                 valid_ff, valid_in;
   scli_pkg::q_item_type item_ff, item_in;
   logic                 accept;

   assign in_ready   = !valid_ff || push_ready;
   assign accept     = in_valid && in_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      item_in               = item_ff;
      item_in.rx_byte       = rx_byte;
      item_in.button_levels = button_levels;
      item_in.adc_level     = adc_level;
      if (rx_byte == scli_pkg::CH_CR) begin
         item_in.kind = scli_pkg::ITEM_EOL;
      end else if (rx_byte == scli_pkg::CH_DEL) begin
         item_in.kind = scli_pkg::ITEM_DEL;
      end else begin
         item_in.kind = scli_pkg::ITEM_CHAR;
      end
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

[sv/scli_queue.sv]
// Small FIFO of tagged items between the input stage and the line engine.
// Depends on scli_pkg.
`default_nettype none

module scli_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire scli_pkg::q_item_type push_item,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output scli_pkg::q_item_type     pop_item
);

   localparam int unsigned PW = $clog2(scli_pkg::QUEUE_DEPTH);

   scli_pkg::q_item_type entry_ff [scli_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;
   logic          push, pop;

   assign push_ready = (fill_ff != (PW+1)'(scli_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(scli_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(scli_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[sv/scli_div.sv]
// Restoring divider: 1000 divided by a 10-bit frequency, one quotient bit a cycle.
// Depends on scli_pkg.
`default_nettype none

module scli_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [scli_pkg::NUM_W-1:0] divisor,
   output logic                            busy,
   output logic                            done,
   output logic [scli_pkg::NUM_W-1:0]      quotient
);

   localparam int unsigned NW = scli_pkg::NUM_W;
   localparam int unsigned CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] dvsr_ff, dvsr_in;
   logic [NW-1:0] dvd_ff, dvd_in;
   logic [NW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [NW:0]   trial;
   logic          fits;

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
   assign trial    = {rem_ff, dvd_ff[NW-1]};
   assign fits     = (trial >= {1'b0, dvsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvsr_in = dvsr_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         dvsr_in = divisor;
         dvd_in  = scli_pkg::PERIOD_MS_NUM;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         // Shift one dividend bit in; subtract when the divisor fits.
         rem_in = fits ? NW'(trial - {1'b0, dvsr_ff}) : trial[NW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         dvd_in = {dvd_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvsr_ff <= dvsr_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

endmodule

`default_nettype wire

[sv/scli_back.sv]
// Line engine: line store, header decode, number scan and result register.
// Depends on scli_pkg; drives the scli_div unit through its start and done ports.
`default_nettype none

module scli_back #(
   parameter int unsigned LINE_DEPTH = scli_pkg::LINE_DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   output logic                            q_ready,
   input  wire scli_pkg::q_item_type       q_item,
   output logic                            div_start,
   output logic [scli_pkg::NUM_W-1:0]      div_divisor,
   input  wire logic                       div_done,
   input  wire logic [scli_pkg::NUM_W-1:0] div_quotient,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output scli_pkg::result_type            rsp_result,
   output scli_pkg::back_status_type       status
);

   localparam int unsigned AW = $clog2(LINE_DEPTH);
   localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
   localparam int unsigned NW = scli_pkg::NUM_W;
   localparam int unsigned HL = scli_pkg::HDR_LEN;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_READ   = 6'b000100,
      ST_EVAL   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        k_ff, k_in;
   logic                 digits_ff, digits_in;
   logic                 neg_ff, neg_in;
   logic [NW-1:0]        num_ff, num_in;
   logic [3:0]           buttons_ff, buttons_in;
   logic [15:0]          adc_ff, adc_in;
   scli_pkg::result_type res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   scli_pkg::result_type rsp_ff, rsp_in;

   logic [7:0] line_mem [LINE_DEPTH];
   logic [7:0] rd_data_ff;
   logic [7:0] hdr_ff [HL];
   logic [7:0] hc [HL];
   logic       mem_we;
   logic [7:0] ev_c;
   logic [NW+3:0] num_x10;
   logic [NW-1:0] num_next;

   assign q_ready     = (state_ff == ST_IDLE);
   assign mem_we      = q_ready && q_valid && (q_item.kind == scli_pkg::ITEM_CHAR) &&
                        (count_ff < CW'(LINE_DEPTH));
   assign div_divisor = num_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_result  = rsp_ff;

   assign status.idle      = (state_ff == ST_IDLE);
   assign status.in_result = (state_ff == ST_RESULT);
   assign status.dividing  = (state_ff == ST_DIVIDE);

   // Line characters as seen by the decoder: CR just past the end, zero beyond.
   always_comb begin
      for (int i = 0; i < HL; i++) begin
         if (CW'(i) < count_ff) begin
            hc[i] = hdr_ff[i];
         end else if (CW'(i) == count_ff) begin
            hc[i] = scli_pkg::CH_CR;
         end else begin
            hc[i] = 8'h00;
         end
      end
   end

   assign ev_c = (k_ff < count_ff) ? rd_data_ff :
                 ((k_ff == count_ff) ? scli_pkg::CH_CR : 8'h00);

   assign num_x10  = ({4'b0, num_ff} << 3) + ({4'b0, num_ff} << 1) + (NW+4)'(ev_c[3:0]);
   assign num_next = (num_x10 > (NW+4)'(scli_pkg::NUM_CAP)) ? scli_pkg::NUM_CAP :
                     num_x10[NW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      digits_in    = digits_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      buttons_in   = buttons_ff;
      adc_in       = adc_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.kind)
                  scli_pkg::ITEM_EOL: begin
                     buttons_in = q_item.button_levels;
                     adc_in     = q_item.adc_level;
                     state_in   = ST_DECODE;
                  end
                  scli_pkg::ITEM_DEL: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  scli_pkg::ITEM_CHAR: begin
                     if (mem_we) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DECODE: begin
            res_in.cmd_kind   = scli_pkg::CMD_INVALID;
            res_in.target     = '0;
            res_in.value      = '0;
            res_in.rate_error = 1'b0;
            state_in          = ST_RESULT;
            if (hc[0] == scli_pkg::CH_SLASH && hc[1] == scli_pkg::CH_F &&
                (hc[2] == scli_pkg::CH_U || hc[2] == scli_pkg::CH_B ||
                 hc[2] == scli_pkg::CH_A || hc[2] == scli_pkg::CH_O)) begin
               res_in.cmd_kind = scli_pkg::CMD_PERIOD;
               if (hc[2] == scli_pkg::CH_U) begin
                  res_in.target = scli_pkg::TGT_UART;
               end else if (hc[2] == scli_pkg::CH_B) begin
                  res_in.target = scli_pkg::TGT_BUTTONS;
               end else if (hc[2] == scli_pkg::CH_A) begin
                  res_in.target = scli_pkg::TGT_ADC;
               end else begin
                  res_in.target = scli_pkg::TGT_OUTPUTS;
               end
               // Scan the number from its fixed start column.
               k_in      = CW'(scli_pkg::NUM_START);
               digits_in = 1'b0;
               neg_in    = 1'b0;
               num_in    = '0;
               state_in  = ST_READ;
            end else if (hc[0] == scli_pkg::CH_SLASH && hc[1] == scli_pkg::CH_B &&
                         scli_pkg::is_digit(hc[2])) begin
               if (hc[2] >= scli_pkg::CH_ONE && hc[2] <= scli_pkg::CH_FOUR) begin
                  res_in.cmd_kind = scli_pkg::CMD_BUTTON;
                  res_in.target   = hc[2][1:0] - 2'd1;
                  res_in.value    = 16'(buttons_ff[hc[2][1:0] - 2'd1]);
               end
            end else if (hc[0] == scli_pkg::CH_SLASH && hc[1] == scli_pkg::CH_O &&
                         scli_pkg::is_digit(hc[2]) && hc[3] == scli_pkg::CH_UNDER &&
                         (hc[4] == scli_pkg::CH_ZERO || hc[4] == scli_pkg::CH_ONE)) begin
               if (hc[2] >= scli_pkg::CH_ONE && hc[2] <= scli_pkg::CH_FOUR) begin
                  res_in.cmd_kind = scli_pkg::CMD_LED;
                  res_in.target   = hc[2][1:0] - 2'd1;
                  res_in.value    = 16'(hc[4][0]);
               end
            end else if (hc[0] == scli_pkg::CH_SLASH && hc[1] == scli_pkg::CH_A) begin
               res_in.cmd_kind = scli_pkg::CMD_ADC;
               res_in.value    = adc_ff;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!digits_ff) begin
               if (scli_pkg::is_space(ev_c) && (k_ff < count_ff)) begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_READ;
               end else if (ev_c == scli_pkg::CH_PLUS || ev_c == scli_pkg::CH_MINUS) begin
                  neg_in    = (ev_c == scli_pkg::CH_MINUS);
                  digits_in = 1'b1;
                  k_in      = k_ff + 1'b1;
                  state_in  = ST_READ;
               end else begin
                  // Same character starts the digit run; read data still holds it.
                  digits_in = 1'b1;
               end
            end else if (scli_pkg::is_digit(ev_c)) begin
               num_in   = num_next;
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end else if (num_ff == '0 || neg_ff) begin
               res_in.value      = '0;
               res_in.rate_error = 1'b1;
               state_in          = ST_RESULT;
            end else if (num_ff > scli_pkg::PERIOD_MS_NUM) begin
               res_in.value = '0;
               state_in     = ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_in.value = 16'(div_quotient);
               state_in     = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      digits_ff  <= digits_in;
      neg_ff     <= neg_in;
      num_ff     <= num_in;
      buttons_ff <= buttons_in;
      adc_ff     <= adc_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // Line store: one write port at the fill count, one registered read at the scan index.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[count_ff[AW-1:0]] <= q_item.rx_byte;
      end
      rd_data_ff <= line_mem[k_ff[AW-1:0]];
   end

   // Shadow copy of the first columns, read directly by the header decode.
   always_ff @(posedge clock) begin
      for (int i = 0; i < HL; i++) begin
         if (mem_we && count_ff == CW'(i)) begin
            hdr_ff[i] <= q_item.rx_byte;
         end
      end
   end

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the serial command line interpreter.
// Needs scli_pkg and the serial_command_line_interpreter top level; nothing else.
`timescale 1ns / 1ps

module tb;
   import scli_pkg::*;

   localparam int unsigned LINE_DEPTH   = scli_pkg::LINE_DEPTH_DEF;
   localparam int unsigned RANDOM_ITEMS = 1160;
   // Longest quiet stretch: a full-length rate line reads and evaluates ~60 columns,
   // plus the divider and a stalled result. Take that many times over.
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned SETTLE_TIME  = 300;
   localparam int unsigned FREQ_SAT     = 100000;

   // Expected command results, computed from the bytes the block has taken.
   class command_scoreboard;
      logic [7:0]      line_buf [LINE_DEPTH];
      int unsigned     line_len;
      result_type      pending_commands [$];
      int unsigned     mismatches;
      int unsigned     bytes_taken;
      int unsigned     bytes_dropped;
      int unsigned     deletes;
      int unsigned     rate_errors;
      int unsigned     kind_count [5];

      function logic [7:0] char_at(input int unsigned k);
         if (k < line_len) return line_buf[k];
         if (k == line_len) return CH_CR;
         return 8'h00;
      endfunction

      function bit is_numeral(input logic [7:0] c);
         return (c >= CH_ZERO) && (c <= CH_NINE);
      endfunction

      // Period in ms from the number at column three; 0 when the number is unusable.
      function bit period_of(output logic [15:0] period);
         int unsigned k;
         int unsigned num;
         logic [7:0]  c;
         bit          neg;
         k = NUM_START;
         num = 0;
         neg = 1'b0;
         c = char_at(k);
         while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            if (k >= line_len) break;
            k++;
            c = char_at(k);
         end
         if (c == CH_PLUS || c == CH_MINUS) begin
            neg = (c == CH_MINUS);
            k++;
            c = char_at(k);
         end
         while (is_numeral(c)) begin
            num = num * 10 + (c - CH_ZERO);
            if (num > FREQ_SAT) num = FREQ_SAT;
            k++;
            c = char_at(k);
         end
         if (num == 0 || neg) begin
            period = 16'd0;
            return 1'b0;
         end
         period = 16'(1000 / num);
         return 1'b1;
      endfunction

      function result_type decode_command(input logic [3:0] buttons, input logic [15:0] adc);
         result_type r;
         logic [7:0] c0, c1, c2, c3, c4;
         c0 = char_at(0);
         c1 = char_at(1);
         c2 = char_at(2);
         c3 = char_at(3);
         c4 = char_at(4);
         r.cmd_kind   = CMD_INVALID;
         r.target     = 2'd0;
         r.value      = 16'd0;
         r.rate_error = 1'b0;
         if (c0 == CH_SLASH && c1 == CH_F &&
             (c2 == CH_U || c2 == CH_B || c2 == CH_A || c2 == CH_O)) begin
            r.cmd_kind = CMD_PERIOD;
            case (c2)
               CH_U:    r.target = TGT_UART;
               CH_B:    r.target = TGT_BUTTONS;
               CH_A:    r.target = TGT_ADC;
               default: r.target = TGT_OUTPUTS;
            endcase
            r.rate_error = !period_of(r.value);
         end else if (c0 == CH_SLASH && c1 == CH_B && is_numeral(c2)) begin
            if (c2 >= CH_ONE && c2 <= CH_FOUR) begin
               r.cmd_kind = CMD_BUTTON;
               r.target   = 2'(c2 - CH_ONE);
               r.value    = {15'd0, buttons[r.target]};
            end
         end else if (c0 == CH_SLASH && c1 == CH_O && is_numeral(c2) && c3 == CH_UNDER &&
                      (c4 == CH_ZERO || c4 == CH_ONE)) begin
            if (c2 >= CH_ONE && c2 <= CH_FOUR) begin
               r.cmd_kind = CMD_LED;
               r.target   = 2'(c2 - CH_ONE);
               r.value    = {15'd0, c4 == CH_ONE};
            end
         end else if (c0 == CH_SLASH && c1 == CH_A) begin
            r.cmd_kind = CMD_ADC;
            r.value    = adc;
         end
         return r;
      endfunction

      function void note_byte(input logic [7:0] b, input logic [3:0] buttons,
                              input logic [15:0] adc);
         result_type r;
         bytes_taken++;
         if (b == CH_CR) begin
            r = decode_command(buttons, adc);
            if (r.rate_error) rate_errors++;
            pending_commands.push_back(r);
            line_len = 0;
         end else if (b == CH_DEL) begin
            deletes++;
            if (line_len > 0) line_len--;
         end else if (line_len < LINE_DEPTH) begin
            line_buf[line_len] = b;
            line_len++;
         end else begin
            bytes_dropped++;
         end
      endfunction

      function void compare_field(input string name, input int unsigned want,
                                  input int unsigned got);
         if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_result(input logic [23:0] tdata);
         result_type want;
         if (pending_commands.size() == 0) begin
            mismatches++;
            $error("result with no command line pending: tdata %h", tdata);
            return;
         end
         want = pending_commands.pop_front();
         if (want.cmd_kind <= CMD_ADC) kind_count[want.cmd_kind]++;
         compare_field("cmd_kind", want.cmd_kind, tdata[2:0]);
         compare_field("target", want.target, tdata[4:3]);
         compare_field("value", want.value, tdata[20:5]);
         compare_field("rate_error", want.rate_error, tdata[21]);
      endfunction

      function int unsigned pending();
         return pending_commands.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;   // rx_byte[7:0], button_levels[11:8], adc_level[27:12]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // cmd_kind[2:0], target[4:3], value[20:5], rate_error[21]

   command_scoreboard commands = new;
   bit                steady_run;     // both sides drop their gaps while this is set
   int unsigned       idle_cycles;

   serial_command_line_interpreter #(.LINE_DEPTH(LINE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one byte and hold it until the block takes it. Lower valid only when a
   // gap follows, so a back-to-back item never sees valid dropped and raised in one step.
   task automatic send_byte(input logic [7:0] b, input logic [3:0] buttons,
                            input logic [15:0] adc);
      int gap;
      gap = steady_run ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, adc, buttons, b};
      do @(posedge clock); while (!req_tready);
      commands.note_byte(b, buttons, adc);
   endtask

   // Byte with random button and ADC readings beside it.
   task automatic send_char(input logic [7:0] b);
      send_byte(b, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
   endtask

   // Whole line plus carriage return, with fixed side readings.
   task automatic send_text(input string s, input logic [3:0] buttons, input logic [15:0] adc);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], buttons, adc);
      send_byte(CH_CR, buttons, adc);
   endtask

   // Hold off the sender until every decoded line has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (commands.pending() != 0);
   endtask

   function automatic logic [7:0] printable();
      return 8'($urandom_range(32, 126));
   endfunction

   // Skippable padding ahead of a number: space or one of the tab-like bytes except CR.
   function automatic logic [7:0] padding();
      int r;
      r = $urandom_range(0, 4);
      return (r == 0) ? CH_SPACE : 8'(CH_TAB + r - 1);
   endfunction

   // Mostly well-formed commands with random content; the rest noise and broken lines.
   task automatic send_random_line();
      logic [7:0] body [$];
      logic [7:0] rate_tgt [4];
      logic [7:0] stub [5];
      int shape;
      int n;
      int pos;
      rate_tgt = '{CH_U, CH_B, CH_A, CH_O};
      shape = $urandom_range(0, 9);
      case (shape)
         0, 1, 2: begin
            body.push_back(CH_SLASH);
            body.push_back(CH_F);
            body.push_back(($urandom_range(0, 9) == 0) ? printable()
                                                        : rate_tgt[$urandom_range(0, 3)]);
            repeat ($urandom_range(0, 2)) body.push_back(padding());
            case ($urandom_range(0, 5))
               0:       body.push_back(CH_PLUS);
               1:       body.push_back(CH_MINUS);
               default: ;
            endcase
            // Keep most numbers short so the useful periods show up often.
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
            repeat (n) body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 3) == 0) body.push_back(printable());
         end
         3: begin
            body.push_back(CH_SLASH);
            body.push_back(CH_B);
            body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 4) == 0) body.push_back(printable());
         end
         4: begin
            body.push_back(CH_SLASH);
            body.push_back(CH_O);
            body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            body.push_back(($urandom_range(0, 7) == 0) ? printable() : CH_UNDER);
            body.push_back(($urandom_range(0, 7) == 0) ? 8'(CH_ZERO + $urandom_range(0, 9))
                                                       : 8'(CH_ZERO + $urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0) body.push_back(printable());
         end
         5: begin
            body.push_back(CH_SLASH);
            body.push_back(CH_A);
            repeat ($urandom_range(0, 5)) body.push_back(printable());
         end
         6: begin
            // Raw noise: any byte at all, carriage returns and deletes included.
            repeat ($urandom_range(0, 8)) body.push_back(8'($urandom_range(0, 255)));
         end
         7: begin
            // Long line that comes near, reaches or runs past the end of the store.
            body.push_back(CH_SLASH);
            body.push_back(CH_F);
            body.push_back(rate_tgt[$urandom_range(0, 3)]);
            repeat ($urandom_range(50, 66)) body.push_back(padding());
            repeat ($urandom_range(1, 6)) body.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
         end
         8: begin
            // Command cut short.
            if ($urandom_range(0, 1) == 0) begin
               stub = '{CH_SLASH, CH_O, CH_ONE, CH_UNDER, CH_ONE};
            end else begin
               stub = '{CH_SLASH, CH_F, CH_U, CH_ONE, CH_ZERO};
            end
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) body.push_back(stub[i]);
         end
         default: begin
            repeat ($urandom_range(1, 6)) body.push_back(printable());
         end
      endcase
      // Typing corrections: junk then delete somewhere in the line, or a stray delete first.
      if ($urandom_range(0, 3) == 0) begin
         pos = $urandom_range(0, body.size());
         body.insert(pos, CH_DEL);
         body.insert(pos, ($urandom_range(0, 5) == 0) ? 8'h00 : printable());
      end
      if ($urandom_range(0, 9) == 0) body.push_front(CH_DEL);
      if ($urandom_range(0, 11) == 0 && body.size() > 0)
         body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
      foreach (body[i]) send_char(body[i]);
      send_char(CH_CR);
   endtask

   // Result side: draw a gap per item, then take the next result and check it.
   initial begin : result_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = steady_run ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         commands.check_result(rsp_tdata);
      end
   end

   initial begin : stimulus
      int unsigned random_start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines: every command, field extremes and the awkward corners.
      steady_run = 1'b0;
      send_text("", 4'h0, 16'h0000);                 // empty line: invalid
      send_text("/fu1", 4'hF, 16'hFFFF);             // slowest valid rate
      send_text("/fb0", 4'h0, 16'h0000);             // zero frequency
      send_text("/fa", 4'h5, 16'h1234);              // missing number
      send_text("/fo-5", 4'hA, 16'h8000);            // negative frequency
      send_text("/fu+7", 4'h3, 16'h0001);
      send_text("/fa \t\n\v\f3", 4'hC, 16'h7FFF);   // skipped padding
      send_text("/fb1001", 4'h0, 16'h0000);          // above 1000: period zero, no error
      send_text("/fo99999999", 4'hF, 16'hFFFF);      // saturating digit run
      send_text("/b1", 4'hF, 16'h0000);
      send_text("/b4", 4'h0, 16'hFFFF);
      send_text("/b0", 4'hF, 16'h0000);              // button digit out of range
      send_text("/b9", 4'hF, 16'h0000);
      send_text("/o1_1", 4'h0, 16'h0000);
      send_text("/o4_0", 4'hF, 16'hFFFF);
      send_text("/o5_1", 4'h0, 16'h0000);            // LED digit out of range
      send_text("/o2_2", 4'h0, 16'h0000);            // bad LED state
      send_text("/a", 4'h0, 16'hFFFF);
      send_text("/axyz", 4'hF, 16'h0000);
      // Delete on an empty line, then a correction in the middle of a command.
      send_byte(CH_DEL, 4'h2, 16'h0000);
      send_byte(CH_SLASH, 4'h2, 16'h0000);
      send_byte(8'h78, 4'h2, 16'h0000);
      send_byte(CH_DEL, 4'h2, 16'h0000);
      send_text("b2", 4'h2, 16'h0000);
      // Zero byte first matches nothing; inside a number it ends the digits.
      send_byte(8'h00, 4'h0, 16'h0000);
      send_text("/a", 4'h0, 16'h0000);
      send_byte(CH_SLASH, 4'h0, 16'h0000);
      send_byte(CH_F, 4'h0, 16'h0000);
      send_byte(CH_U, 4'h0, 16'h0000);
      send_byte(8'h32, 4'h0, 16'h0000);
      send_byte(8'h00, 4'h0, 16'h0000);
      send_text("5", 4'h0, 16'h0000);
      // Full store: the tail past the last slot is dropped, the stored line still decodes.
      send_byte(CH_SLASH, 4'h0, 16'h0000);
      send_byte(CH_F, 4'h0, 16'h0000);
      send_byte(CH_U, 4'h0, 16'h0000);
      repeat (LINE_DEPTH - 6) send_byte(CH_SPACE, 4'h0, 16'h0000);
      send_text("2559999", 4'h0, 16'h0000);

      // Pressure: let every result come back before the random part.
      drain();

      random_start = commands.bytes_taken;
      while (commands.bytes_taken < random_start + RANDOM_ITEMS) begin
         steady_run = ($urandom_range(0, 7) == 0);
         send_random_line();
         if ($urandom_range(0, 39) == 0) drain();
      end

      // Drain, then give the block time to show any stray result.
      steady_run = 1'b0;
      drain();
      repeat (SETTLE_TIME) @(posedge clock);

      $display("Covered %0d bytes: %0d invalid, %0d rate, %0d button, %0d LED, %0d ADC lines.",
               commands.bytes_taken, commands.kind_count[CMD_INVALID],
               commands.kind_count[CMD_PERIOD], commands.kind_count[CMD_BUTTON],
               commands.kind_count[CMD_LED], commands.kind_count[CMD_ADC]);
      $display("Rate errors %0d, deletes %0d, bytes dropped on a full line %0d.",
               commands.rate_errors, commands.deletes, commands.bytes_dropped);
      if (commands.mismatches == 0 && commands.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
